// File: rtl/lcdw_pkg.sv
package lcdw_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int DIGITS = (NUMBER_WIDTH * 30103) / 100000 + 1;
   localparam int SHIFT_CNT_W = $clog2(NUMBER_WIDTH + 1);
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

   localparam logic [1:0] CMD_INSTR  = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_CURSOR = 2'd2;
   localparam logic [1:0] CMD_NUMBER = 2'd3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;
   localparam logic BACKLIGHT_ON = 1'b1;

   typedef struct packed {
      logic [1:0]              command;
      logic [7:0]              byte_value;
      logic [1:0]              row;
      logic [4:0]              column;
      logic [NUMBER_WIDTH-1:0] number;
   } lcdw_req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last_of_run;
   } lcdw_rsp_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } lcdw_chain_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_NEXT,
      ST_EMIT
   } lcdw_state_type;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_SIGN,
      KIND_DIGIT
   } lcdw_kind_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h94;
         2'd3: base = 8'hD4;
         default: base = 8'h80;
      endcase
      return base;
   endfunction

endpackage

// File: rtl/lcdw_digit_cell.sv
module lcdw_digit_cell (
   input  logic                        clock,
   input  lcdw_pkg::lcdw_chain_ctrl_type ctrl,
   input  logic                        bit_in,
   input  logic [3:0]                  digit_prev,
   output logic                        bit_out,
   output logic [3:0]                  digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adjusted;

   // A digit of five or more is corrected before the shift so that it carries.
   assign adjusted = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out = adjusted[3];
   assign digit = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in = digit_prev;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// File: rtl/lcdw_digit_chain.sv
module lcdw_digit_chain (
   input  logic                        clock,
   input  lcdw_pkg::lcdw_chain_ctrl_type ctrl,
   input  logic                        bit_in,
   output logic [3:0]                  top_digit
);

   logic [lcdw_pkg::DIGITS:0] carry;
   logic [3:0]                digit_link [lcdw_pkg::DIGITS+1];

   assign carry[0] = bit_in;
   assign digit_link[0] = 4'd0;

   for (genvar i = 0; i < lcdw_pkg::DIGITS; i++) begin : g_cell
      lcdw_digit_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .bit_in     (carry[i]),
         .digit_prev (digit_link[i]),
         .bit_out    (carry[i+1]),
         .digit      (digit_link[i+1])
      );
   end

   assign top_digit = digit_link[lcdw_pkg::DIGITS];

endmodule

// File: rtl/char_lcd_expander_writer.sv
// Instruction, character and cursor transactions give 4 results on consecutive cycles,
// the first in the cycle after acceptance; busy stays high through them and no new one is taken.
// A number transaction shifts its magnitude into the decimal digit cells, emits the sign
// for a negative number only, skips each leading zero but the last digit, then emits each
// remaining digit; busy stays high throughout and no new one is taken. Results cannot be stalled.
// Synchronous reset returns the block to idle with busy low.
module char_lcd_expander_writer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lcdw_pkg::lcdw_req_type req_data,
   output logic                  rsp_valid,
   output lcdw_pkg::lcdw_rsp_type rsp_data
);

   lcdw_pkg::lcdw_state_type      state_ff, state_in;
   lcdw_pkg::lcdw_kind_type       kind_ff, kind_in;
   logic [1:0]                    phase_ff, phase_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          rs_ff, rs_in;
   logic                          neg_ff, neg_in;
   logic [lcdw_pkg::NUMBER_WIDTH-1:0] mag_ff, mag_in;
   logic [lcdw_pkg::SHIFT_CNT_W-1:0]  shift_cnt_ff, shift_cnt_in;
   logic [lcdw_pkg::DIGIT_CNT_W-1:0]  ndig_ff, ndig_in;

   lcdw_pkg::lcdw_chain_ctrl_type chain_ctrl;
   logic [3:0]                    top_digit;
   logic                          accept;
   logic                          last_digit;
   logic                          top_zero;
   logic [3:0]                    nibble;

   assign accept = start && (state_ff == lcdw_pkg::ST_IDLE);
   assign last_digit = (ndig_ff == lcdw_pkg::DIGIT_CNT_W'(1));
   assign top_zero = (top_digit == 4'd0);

   lcdw_digit_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .bit_in    (mag_ff[lcdw_pkg::NUMBER_WIDTH-1]),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcdw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_data.command == lcdw_pkg::CMD_NUMBER) ?
                          lcdw_pkg::ST_CONVERT : lcdw_pkg::ST_EMIT;
            end
         end
         lcdw_pkg::ST_CONVERT: begin
            if (shift_cnt_ff == lcdw_pkg::SHIFT_CNT_W'(1)) begin
               state_in = neg_ff ? lcdw_pkg::ST_EMIT : lcdw_pkg::ST_TRIM;
            end
         end
         lcdw_pkg::ST_TRIM: begin
            if (!(top_zero && !last_digit)) begin
               state_in = lcdw_pkg::ST_EMIT;
            end
         end
         lcdw_pkg::ST_NEXT: begin
            state_in = lcdw_pkg::ST_EMIT;
         end
         lcdw_pkg::ST_EMIT: begin
            if (phase_ff == 2'd3) begin
               case (kind_ff)
                  lcdw_pkg::KIND_SIGN:  state_in = lcdw_pkg::ST_TRIM;
                  lcdw_pkg::KIND_DIGIT: state_in = last_digit ? lcdw_pkg::ST_IDLE :
                                                                lcdw_pkg::ST_NEXT;
                  default:              state_in = lcdw_pkg::ST_IDLE;
               endcase
            end
         end
         default: state_in = lcdw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != lcdw_pkg::ST_IDLE);
      rsp_valid = (state_ff == lcdw_pkg::ST_EMIT);
      nibble = phase_ff[1] ? byte_ff[3:0] : byte_ff[7:4];
      rsp_data.expander_byte = {nibble, lcdw_pkg::BACKLIGHT_ON, ~phase_ff[0], 1'b0, rs_ff};
      rsp_data.last_of_run = (phase_ff == 2'd3) &&
                             ((kind_ff == lcdw_pkg::KIND_SINGLE) ||
                              ((kind_ff == lcdw_pkg::KIND_DIGIT) && last_digit));
      chain_ctrl.clear = (state_ff == lcdw_pkg::ST_IDLE);
      chain_ctrl.dabble = (state_ff == lcdw_pkg::ST_CONVERT);
      chain_ctrl.move = ((state_ff == lcdw_pkg::ST_TRIM) && top_zero && !last_digit) ||
                        ((state_ff == lcdw_pkg::ST_EMIT) && (phase_ff == 2'd3) &&
                         (kind_ff == lcdw_pkg::KIND_DIGIT) && !last_digit);
   end

   always_comb begin
      kind_in = kind_ff;
      phase_in = phase_ff;
      byte_in = byte_ff;
      rs_in = rs_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      shift_cnt_in = shift_cnt_ff;
      ndig_in = ndig_ff;
      case (state_ff)
         lcdw_pkg::ST_IDLE: begin
            phase_in = 2'd0;
            kind_in = lcdw_pkg::KIND_SINGLE;
            neg_in = req_data.number[lcdw_pkg::NUMBER_WIDTH-1];
            mag_in = req_data.number[lcdw_pkg::NUMBER_WIDTH-1] ?
                     (~req_data.number + lcdw_pkg::NUMBER_WIDTH'(1)) : req_data.number;
            shift_cnt_in = lcdw_pkg::SHIFT_CNT_W'(lcdw_pkg::NUMBER_WIDTH);
            ndig_in = lcdw_pkg::DIGIT_CNT_W'(lcdw_pkg::DIGITS);
            case (req_data.command)
               lcdw_pkg::CMD_INSTR: begin
                  byte_in = req_data.byte_value;
                  rs_in = 1'b0;
               end
               lcdw_pkg::CMD_CHAR: begin
                  byte_in = req_data.byte_value;
                  rs_in = 1'b1;
               end
               lcdw_pkg::CMD_CURSOR: begin
                  byte_in = lcdw_pkg::row_base(req_data.row) + {3'b000, req_data.column};
                  rs_in = 1'b0;
               end
               default: begin
                  byte_in = lcdw_pkg::CHAR_MINUS;
                  rs_in = 1'b1;
               end
            endcase
         end
         lcdw_pkg::ST_CONVERT: begin
            mag_in = {mag_ff[lcdw_pkg::NUMBER_WIDTH-2:0], 1'b0};
            shift_cnt_in = shift_cnt_ff - lcdw_pkg::SHIFT_CNT_W'(1);
            kind_in = lcdw_pkg::KIND_SIGN;
            phase_in = 2'd0;
         end
         lcdw_pkg::ST_TRIM: begin
            if (top_zero && !last_digit) begin
               ndig_in = ndig_ff - lcdw_pkg::DIGIT_CNT_W'(1);
            end else begin
               byte_in = {lcdw_pkg::CHAR_DIGIT_HI, top_digit};
               rs_in = 1'b1;
               kind_in = lcdw_pkg::KIND_DIGIT;
               phase_in = 2'd0;
            end
         end
         lcdw_pkg::ST_NEXT: begin
            byte_in = {lcdw_pkg::CHAR_DIGIT_HI, top_digit};
            phase_in = 2'd0;
         end
         lcdw_pkg::ST_EMIT: begin
            phase_in = phase_ff + 2'd1;
            if ((phase_ff == 2'd3) && (kind_ff == lcdw_pkg::KIND_DIGIT) && !last_digit) begin
               ndig_in = ndig_ff - lcdw_pkg::DIGIT_CNT_W'(1);
            end
         end
         default: begin
            phase_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdw_pkg::ST_IDLE;
         phase_ff <= 2'd0;
         kind_ff <= lcdw_pkg::KIND_SINGLE;
      end else begin
         state_ff <= accept || (state_ff != lcdw_pkg::ST_IDLE) ? state_in : lcdw_pkg::ST_IDLE;
         phase_ff <= phase_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff <= rs_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      shift_cnt_ff <= shift_cnt_in;
      ndig_ff <= ndig_in;
   end

endmodule
